[hdl/sorted_priority_queue_assert.svh]
// Assertion macros used by the RTL
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define SPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

[hdl/spq_pkg.sv]
package spq_pkg;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_REPORT = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	typedef struct packed {
		logic insert;
		logic remove;
		logic sel_lt;
	} spq_ctrl_t;

endpackage

[hdl/spq_cell.sv]
module spq_cell #(
	parameter int KEY_BITS    = 48,
	parameter int HANDLE_BITS = 9
) (
	input  logic                   clk,
	input  logic                   cmp_en,
	input  logic                   occ,
	input  logic [KEY_BITS-1:0]    new_key,
	input  logic [HANDLE_BITS-1:0] new_hnd,
	input  spq_pkg::spq_ctrl_t     ctrl,
	input  logic                   prev_below,
	input  logic [KEY_BITS-1:0]    prev_key,
	input  logic [HANDLE_BITS-1:0] prev_hnd,
	input  logic [KEY_BITS-1:0]    next_key,
	input  logic [HANDLE_BITS-1:0] next_hnd,
	output logic [KEY_BITS-1:0]    key,
	output logic [HANDLE_BITS-1:0] hnd,
	output logic                   lt,
	output logic                   le,
	output logic                   below,
	output logic [KEY_BITS-1:0]    key_nxt,
	output logic [HANDLE_BITS-1:0] hnd_nxt
);
	import spq_pkg::*;

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic                   lt_q;
	logic                   le_q;

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			lt_q <= occ && (key_q < new_key);
			le_q <= occ && (key_q <= new_key);
		end
	end

	always_comb begin
		below   = ctrl.sel_lt ? lt_q : le_q;
		key_nxt = key_q;
		hnd_nxt = hnd_q;
		if (ctrl.remove) begin
			key_nxt = next_key;
			hnd_nxt = next_hnd;
		end else if (ctrl.insert && !below) begin
			if (prev_below) begin
				key_nxt = new_key;
				hnd_nxt = new_hnd;
			end else begin
				key_nxt = prev_key;
				hnd_nxt = prev_hnd;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_nxt;
		hnd_q <= hnd_nxt;
	end

	assign key = key_q;
	assign hnd = hnd_q;
	assign lt  = lt_q;
	assign le  = le_q;

endmodule

[hdl/sorted_priority_queue.sv]
// Sorted priority queue, smallest priority at the head.
// Input channel (in_valid/in_ready) carries one word per command: cmd, handle,
// priority_req. cmd 0 inserts, 1 removes the head, 2 (and 3) only reports.
// Output channel (out_valid/out_ready) returns one word per command: the head
// entry, empty flag, count and status as they stand after the command.
// Storage is a row of DEPTH cells, one entry each, kept in ascending order.
// Every cell compares its key with the incoming priority in the cycle the
// word is accepted; in the next cycle the run boundaries are encoded, the
// insert position chosen, and every cell loads its own, its neighbour's or
// the new entry at once. The result is registered at the end of that cycle.
// A new command is taken only after the previous one has passed both its
// compare cycle and its shift cycle.
// A full queue rejects an insert with status 2; a remove on an empty queue
// reports status 1. Reset empties the queue and drops any pending result.
// While the receiver stalls, the result word holds and no command is taken.
module sorted_priority_queue #(
	parameter int DEPTH       = 256,
	parameter int KEY_BITS    = 48,
	parameter int HANDLE_BITS = 9
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    cmd,
	input  logic [HANDLE_BITS-1:0]        handle,
	input  logic [KEY_BITS-1:0]           priority_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [HANDLE_BITS-1:0]        head_handle,
	output logic [KEY_BITS-1:0]           head_priority,
	output logic                          empty_res,
	output logic [$clog2(DEPTH+1)-1:0]    count,
	output logic [1:0]                    status
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic                   state_q;
	logic [CW-1:0]          count_q;
	logic [1:0]             cmd_q;
	logic [HANDLE_BITS-1:0] hnd_q;
	logic [KEY_BITS-1:0]    key_q;

	logic                   out_valid_q;
	logic [HANDLE_BITS-1:0] head_hnd_q;
	logic [KEY_BITS-1:0]    head_key_q;
	logic                   empty_q;
	logic [CW-1:0]          out_count_q;
	logic [1:0]             status_q;

	logic                   accept;
	logic [DEPTH-1:0]       occ;
	logic [DEPTH-1:0]       lt_v;
	logic [DEPTH-1:0]       le_v;
	logic [DEPTH-1:0]       below_v;
	logic [DEPTH:0]         lt_ext;
	logic [DEPTH:0]         le_ext;
	logic [CW-1:0]          lt_cnt;
	logic [CW-1:0]          le_cnt;
	logic [CW-1:0]          count_nxt;
	logic [1:0]             status_nxt;
	spq_ctrl_t              ctrl;

	logic [KEY_BITS-1:0]    cell_key [DEPTH];
	logic [HANDLE_BITS-1:0] cell_hnd [DEPTH];
	logic [KEY_BITS-1:0]    head_key_nxt;
	logic [HANDLE_BITS-1:0] head_hnd_nxt;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			logic                   pb;
			logic [KEY_BITS-1:0]    pk;
			logic [HANDLE_BITS-1:0] ph;
			logic [KEY_BITS-1:0]    nk;
			logic [HANDLE_BITS-1:0] nh;
			logic [KEY_BITS-1:0]    kn;
			logic [HANDLE_BITS-1:0] hn;

			assign occ[g] = CW'(g) < count_q;

			if (g == 0) begin : g_first
				assign pb = 1'b0;
				assign pk = key_q;
				assign ph = hnd_q;
				assign head_key_nxt = kn;
				assign head_hnd_nxt = hn;
			end else begin : g_mid
				assign pb = below_v[g-1];
				assign pk = cell_key[g-1];
				assign ph = cell_hnd[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign nk = cell_key[g];
				assign nh = cell_hnd[g];
			end else begin : g_inner
				assign nk = cell_key[g+1];
				assign nh = cell_hnd[g+1];
			end

			spq_cell #(
				.KEY_BITS   (KEY_BITS),
				.HANDLE_BITS(HANDLE_BITS)
			) u_cell (
				.clk       (clk),
				.cmp_en    (accept),
				.occ       (occ[g]),
				.new_key   (accept ? priority_req : key_q),
				.new_hnd   (hnd_q),
				.ctrl      (ctrl),
				.prev_below(pb),
				.prev_key  (pk),
				.prev_hnd  (ph),
				.next_key  (nk),
				.next_hnd  (nh),
				.key       (cell_key[g]),
				.hnd       (cell_hnd[g]),
				.lt        (lt_v[g]),
				.le        (le_v[g]),
				.below     (below_v[g]),
				.key_nxt   (kn),
				.hnd_nxt   (hn)
			);
		end
	endgenerate

	assign lt_ext = {1'b0, lt_v};
	assign le_ext = {1'b0, le_v};

	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (lt_ext[i] && !lt_ext[i+1])
				lt_cnt = lt_cnt | CW'(i + 1);
			if (le_ext[i] && !le_ext[i+1])
				le_cnt = le_cnt | CW'(i + 1);
		end
	end

	always_comb begin
		ctrl        = '0;
		ctrl.sel_lt = ({1'b0, lt_cnt} + {1'b0, le_cnt}) <= {1'b0, count_q};
		count_nxt   = count_q;
		status_nxt  = STAT_OK;
		if (state_q == S_EXEC) begin
			case (cmd_q)
				CMD_INSERT: begin
					if (count_q == CW'(DEPTH)) begin
						status_nxt = STAT_FULL;
					end else begin
						ctrl.insert = 1'b1;
						count_nxt   = count_q + CW'(1);
					end
				end
				CMD_REMOVE: begin
					if (count_q == '0) begin
						status_nxt = STAT_UNDERFLOW;
					end else begin
						ctrl.remove = 1'b1;
						count_nxt   = count_q - CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			hnd_q <= handle;
			key_q <= priority_req;
		end
		if (state_q == S_EXEC) begin
			head_hnd_q  <= (count_nxt == '0) ? '0 : head_hnd_nxt;
			head_key_q  <= (count_nxt == '0) ? '0 : head_key_nxt;
			empty_q     <= count_nxt == '0;
			out_count_q <= count_nxt;
			status_q    <= status_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && out_ready)
						out_valid_q <= 1'b0;
					if (accept)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign head_handle   = head_hnd_q;
	assign head_priority = head_key_q;
	assign empty_res     = empty_q;
	assign count         = out_count_q;
	assign status        = status_q;

`include "sorted_priority_queue_assert.svh"

	`SPQ_ASSERT_NOW(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`SPQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC && !in_ready)
	`SPQ_ASSERT_NEXT(a_exec_result, clk, arst_n, state_q == S_EXEC, out_valid_q && out_count_q == count_q)
	`SPQ_ASSERT_NOW(a_full_status, clk, arst_n, out_valid_q && status_q == STAT_FULL, out_count_q == CW'(DEPTH) && !empty_q)

endmodule

[tb/tb_sorted_priority_queue.sv]
module tb_sorted_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int DEPTH       = 256;
	localparam int KEY_BITS    = 48;
	localparam int HANDLE_BITS = 9;
	localparam int CNT_BITS    = $clog2(DEPTH + 1);
	localparam int QUIET_TAIL  = 150;
	localparam int SETTLE      = 20;
	localparam int REPORT_MAX  = 10;

	localparam logic [1:0] CMD_SPARE = 2'd3;

	localparam logic [KEY_BITS-1:0] KEY_MAX = {KEY_BITS{1'b1}};

	typedef struct packed {
		logic [1:0]             op;
		logic [HANDLE_BITS-1:0] hnd;
		logic [KEY_BITS-1:0]    key;
	} spq_cmd_word_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] hnd;
		logic [KEY_BITS-1:0]    key;
		logic                   empty;
		logic [CNT_BITS-1:0]    cnt;
		logic [1:0]             stat;
	} spq_head_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             cmd = CMD_REPORT;
	logic [HANDLE_BITS-1:0] handle = '0;
	logic [KEY_BITS-1:0]    priority_req = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [HANDLE_BITS-1:0] head_handle;
	logic [KEY_BITS-1:0]    head_priority;
	logic                   empty_res;
	logic [CNT_BITS-1:0]    count;
	logic [1:0]             status;

	sorted_priority_queue #(
		.DEPTH      (DEPTH),
		.KEY_BITS   (KEY_BITS),
		.HANDLE_BITS(HANDLE_BITS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.handle       (handle),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.head_handle  (head_handle),
		.head_priority(head_priority),
		.empty_res    (empty_res),
		.count        (count),
		.status       (status)
	);

	always #4 clk = ~clk;

	spq_cmd_word_t    cmd_words[$];
	spq_head_report_t expected_reports[$];
	spq_cmd_word_t    next_word;
	spq_head_report_t want;

	logic [KEY_BITS-1:0]    shadow_key[DEPTH];
	logic [HANDLE_BITS-1:0] shadow_hnd[DEPTH];
	int unsigned            shadow_fill = 0;

	int plan_fill = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int mismatches = 0;
	int reports_seen = 0;
	int n_insert = 0, n_remove = 0, n_report = 0;
	int n_full = 0, n_underflow = 0, peak_fill = 0;

	function automatic spq_head_report_t queue_after_cmd(spq_cmd_word_t w);
		int unsigned lt, le, pos;
		spq_head_report_t r;
		r.stat = STAT_OK;
		lt = 0;
		le = 0;
		if (w.op == CMD_INSERT) begin
			n_insert++;
			if (shadow_fill >= DEPTH) begin
				r.stat = STAT_FULL;
				n_full++;
			end else begin
				for (int i = 0; i < shadow_fill; i++) begin
					if (shadow_key[i] < w.key)
						lt++;
					if (shadow_key[i] <= w.key)
						le++;
				end
				pos = (lt + le <= shadow_fill) ? lt : le;
				for (int i = shadow_fill; i > pos; i--) begin
					shadow_key[i] = shadow_key[i-1];
					shadow_hnd[i] = shadow_hnd[i-1];
				end
				shadow_key[pos] = w.key;
				shadow_hnd[pos] = w.hnd;
				shadow_fill++;
				if (shadow_fill > peak_fill)
					peak_fill = shadow_fill;
			end
		end else if (w.op == CMD_REMOVE) begin
			n_remove++;
			if (shadow_fill == 0) begin
				r.stat = STAT_UNDERFLOW;
				n_underflow++;
			end else begin
				for (int i = 0; i + 1 < shadow_fill; i++) begin
					shadow_key[i] = shadow_key[i+1];
					shadow_hnd[i] = shadow_hnd[i+1];
				end
				shadow_fill--;
			end
		end else begin
			n_report++;
		end
		r.hnd   = (shadow_fill > 0) ? shadow_hnd[0] : '0;
		r.key   = (shadow_fill > 0) ? shadow_key[0] : '0;
		r.empty = (shadow_fill == 0);
		r.cnt   = CNT_BITS'(shadow_fill);
		return r;
	endfunction

	function automatic logic [KEY_BITS-1:0] rand_key();
		case ($urandom_range(0, 4))
			0: return KEY_BITS'($urandom_range(0, 7));
			1: return KEY_BITS'($urandom_range(0, 1000));
			2: return ($urandom_range(0, 1) != 0) ? KEY_MAX : KEY_MAX - KEY_BITS'($urandom_range(0, 3));
			default: return KEY_BITS'({$urandom, $urandom});
		endcase
	endfunction

	task automatic add_word(logic [1:0] op, logic [HANDLE_BITS-1:0] h, logic [KEY_BITS-1:0] k);
		spq_cmd_word_t w;
		w.op = op;
		w.hnd = h;
		w.key = k;
		cmd_words.push_back(w);
		if (op == CMD_INSERT && plan_fill < DEPTH)
			plan_fill++;
		else if (op == CMD_REMOVE && plan_fill > 0)
			plan_fill--;
	endtask

	task automatic add_random(int ins_pct, int rem_pct);
		int r;
		logic [1:0] op;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			op = CMD_INSERT;
		else if (r < ins_pct + rem_pct)
			op = CMD_REMOVE;
		else if (r < 97)
			op = CMD_REPORT;
		else
			op = CMD_SPARE;
		add_word(op, HANDLE_BITS'($urandom), rand_key());
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				expected_reports.push_back(queue_after_cmd({cmd, handle, priority_req}));
			if (!in_valid || in_ready) begin
				if (send_gap == 0 && cmd_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 16);
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (cmd_words.size() > 0) begin
					next_word = cmd_words.pop_front();
					in_valid <= 1'b1;
					cmd <= next_word.op;
					handle <= next_word.hnd;
					priority_req <= next_word.key;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("unexpected result word: h=%0d p=%h e=%b n=%0d s=%0d",
							head_handle, head_priority, empty_res, count, status);
				end else begin
					want = expected_reports.pop_front();
					reports_seen++;
					if (head_handle !== want.hnd || head_priority !== want.key ||
						empty_res !== want.empty || count !== want.cnt ||
						status !== want.stat) begin
						mismatches++;
						if (mismatches <= REPORT_MAX)
							$display("word %0d: expected h=%0d p=%h e=%b n=%0d s=%0d, got h=%0d p=%h e=%b n=%0d s=%0d",
								reports_seen, want.hnd, want.key, want.empty, want.cnt,
								want.stat, head_handle, head_priority, empty_res, count,
								status);
					end
				end
			end
			if (recv_stall == 0 && cmd_words.size() > QUIET_TAIL && $urandom_range(0, 9) == 0)
				recv_stall = $urandom_range(1, 16);
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		// empty queue, underflow, spare code
		add_word(CMD_REPORT, '1, KEY_MAX);
		add_word(CMD_REMOVE, '0, '0);
		add_word(CMD_SPARE, 9'h155, 48'h5555_5555_5555);
		// ordering and placement within runs of equal keys
		add_word(CMD_INSERT, '1, KEY_MAX);
		add_word(CMD_INSERT, '0, '0);
		add_word(CMD_INSERT, 9'd5, 48'd100);
		add_word(CMD_INSERT, 9'd6, 48'd100);
		add_word(CMD_INSERT, 9'd7, 48'd100);
		add_word(CMD_INSERT, 9'd8, 48'd100);
		add_word(CMD_INSERT, 9'd9, KEY_MAX);
		add_word(CMD_INSERT, 9'd1, '0);
		add_word(CMD_INSERT, 9'h0AA, 48'hAAAA_AAAA_AAAA);
		add_word(CMD_INSERT, 9'h155, 48'h5555_5555_5555);
		add_word(CMD_SPARE, 9'h0AA, 48'hAAAA_AAAA_AAAA);
		add_word(CMD_REPORT, 9'h1FF, '0);
		repeat (6)
			add_word(CMD_REMOVE, HANDLE_BITS'($urandom), KEY_BITS'({$urandom, $urandom}));
		add_word(CMD_INSERT, 9'h100, 48'h8000_0000_0000);
		add_word(CMD_REMOVE, '0, '0);
		add_word(CMD_REPORT, '0, '0);

		repeat (600)
			add_random(55, 35);
		// fill to the top, push past it, then drain past empty
		while (plan_fill < DEPTH) begin
			if ($urandom_range(0, 15) == 0)
				add_word(CMD_REPORT, HANDLE_BITS'($urandom), rand_key());
			add_word(CMD_INSERT, HANDLE_BITS'($urandom), rand_key());
		end
		repeat (5)
			add_word(CMD_INSERT, HANDLE_BITS'($urandom), rand_key());
		add_word(CMD_REPORT, '0, '0);
		while (plan_fill > 0) begin
			if ($urandom_range(0, 15) == 0)
				add_word(CMD_SPARE, HANDLE_BITS'($urandom), rand_key());
			add_word(CMD_REMOVE, HANDLE_BITS'($urandom), rand_key());
		end
		repeat (3)
			add_word(CMD_REMOVE, HANDLE_BITS'($urandom), rand_key());
		repeat (650)
			add_random(45, 45);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_words.size() > 0 || in_valid)
			@(posedge clk);
		while (expected_reports.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d commands: %0d inserts, %0d removes, %0d report-only",
			n_insert + n_remove + n_report, n_insert, n_remove, n_report);
		$display("inserts refused when full: %0d, removes on empty: %0d, peak depth %0d",
			n_full, n_underflow, peak_fill);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatching result words", mismatches);
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timed out with %0d words pending", expected_reports.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
